// ===== design/utaf_pkg.sv =====
// Package for the unsigned-to-ASCII formatter: item types, conversion codes,
// sizing defaults and the digit-to-character function.
// No dependencies.
package utaf_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_DIGITS_DEF = 22;
  localparam int QUEUE_DEPTH    = 2;

  // conversion codes
  localparam logic [2:0] OP_DEC    = 3'd0;
  localparam logic [2:0] OP_HEX_LO = 3'd1;
  localparam logic [2:0] OP_HEX_UP = 3'd2;
  localparam logic [2:0] OP_OCT    = 3'd3;
  localparam logic [2:0] OP_PTR    = 3'd4;

  // length modes
  localparam logic [2:0] LM_INT   = 3'd0;
  localparam logic [2:0] LM_LONG  = 3'd1;
  localparam logic [2:0] LM_LLONG = 3'd2;
  localparam logic [2:0] LM_SHORT = 3'd3;
  localparam logic [2:0] LM_CHAR  = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_HEX,
    BASE_OCT
  } base_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PFX0,
    ST_PFX1,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  length_mode;
    logic [63:0] value;
    logic        precision_zero;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  typedef struct packed {
    base_e base;
    logic  upper;
    logic  ptr;
    logic  no_digits;
  } cmd_ctrl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) return CH_ZERO + d8;
    else if (upper) return CH_UP_A + d8 - 8'd10;
    else return CH_LO_A + d8 - 8'd10;
  endfunction

endpackage

// ===== design/utaf_front.sv =====
// Front end: classifies an incoming item (base, case, prefix, zero pointer)
// and cuts the value to its length mode. Depends on utaf_pkg.
module utaf_front #(
  parameter int VALUE_BITS = utaf_pkg::VALUE_BITS_DEF
) (
  input  utaf_pkg::in_item_t  in_i,
  output utaf_pkg::cmd_ctrl_t ctrl_o,
  output logic [VALUE_BITS-1:0] value_o
);
  import utaf_pkg::*;

  logic        ptr;
  logic [63:0] masked;

  assign ptr = (in_i.op == OP_PTR);

  always_comb begin
    priority if (ptr || in_i.length_mode == LM_LONG || in_i.length_mode == LM_LLONG) begin
      masked = in_i.value;
    end else if (in_i.length_mode == LM_SHORT) begin
      masked = {48'd0, in_i.value[15:0]};
    end else if (in_i.length_mode == LM_CHAR) begin
      masked = {56'd0, in_i.value[7:0]};
    end else begin
      masked = {32'd0, in_i.value[31:0]};
    end
  end

  assign value_o = masked[VALUE_BITS-1:0];

  always_comb begin
    ctrl_o.upper     = (in_i.op == OP_HEX_UP);
    ctrl_o.ptr       = ptr;
    ctrl_o.no_digits = ptr && (value_o == '0) && in_i.precision_zero;
    unique case (in_i.op)
      OP_HEX_LO, OP_HEX_UP, OP_PTR: ctrl_o.base = BASE_HEX;
      OP_OCT:                       ctrl_o.base = BASE_OCT;
      default:                      ctrl_o.base = BASE_DEC;
    endcase
  end

endmodule

// ===== design/utaf_fifo.sv =====
// Short command queue between front and back end.
// No package dependency.
module utaf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/utaf_back.sv =====
// Back end: forms the digits (double dabble for decimal, direct bit groups for
// hex and octal), drops leading zeros and emits characters into an output
// register. Depends on utaf_pkg.
module utaf_back #(
  parameter int VALUE_BITS = utaf_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = utaf_pkg::MAX_DIGITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  utaf_pkg::cmd_ctrl_t   cmd_ctrl_i,
  input  logic [VALUE_BITS-1:0] cmd_value_i,
  output logic                  cmd_pop_o,
  output logic                  busy_o,
  input  logic                  out_pop_i,
  output logic                  out_empty_o,
  output utaf_pkg::out_item_t   out_o
);
  import utaf_pkg::*;

  localparam int DEC_DIGITS = VALUE_BITS * 30103 / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int FULL       = OCT_DIGITS;
  localparam int CAP        = (MAX_DIGITS < FULL) ? MAX_DIGITS : FULL;
  localparam int REM_W      = $clog2(FULL + 1);
  localparam int IDX_W      = $clog2(FULL);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  state_e                state_q, state_d;
  cmd_ctrl_t             ctrl_q, ctrl_d;
  logic [VALUE_BITS-1:0] sh_q, sh_d;
  logic [3:0]            dig_q [FULL];
  logic [3:0]            dig_d [FULL];
  logic [3:0]            adj   [FULL];
  logic [REM_W-1:0]      rem_q, rem_d;
  logic                  seen_q, seen_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic [FULL*4-1:0]     ext;
  logic [IDX_W-1:0]      top_idx;
  logic [3:0]            top_dig;
  logic                  slot_free;
  logic                  skip_go;

  assign ext         = (FULL * 4)'(cmd_value_i);
  assign top_idx     = IDX_W'(rem_q - REM_W'(1));
  assign top_dig     = dig_q[top_idx];
  assign slot_free   = !out_valid_q || out_pop_i;
  // past the digit cap everything is dropped; below it only leading zeros,
  // unless a nonzero digit was dropped (truncated result keeps its zeros)
  assign skip_go     = (rem_q > REM_W'(CAP)) ||
                       (!seen_q && (rem_q > REM_W'(1)) && (top_dig == 4'd0));
  assign busy_o      = (state_q != ST_IDLE);
  assign out_empty_o = !out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    for (int i = 0; i < FULL; i++) begin
      adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_ctrl_i.base == BASE_DEC) ? ST_CONV : ST_SKIP;
        end
      end
      ST_CONV: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!skip_go) state_d = ctrl_q.ptr ? ST_PFX0 : ST_EMIT;
      end
      ST_PFX0: begin
        if (slot_free) state_d = ST_PFX1;
      end
      ST_PFX1: begin
        if (slot_free) state_d = ctrl_q.no_digits ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free && rem_q == REM_W'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop_o   = 1'b0;
    ctrl_d      = ctrl_q;
    sh_d        = sh_q;
    dig_d       = dig_q;
    rem_d       = rem_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_pop_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i) begin
          ctrl_d = cmd_ctrl_i;
          sh_d   = cmd_value_i;
          cnt_d  = CNT_W'(VALUE_BITS);
          seen_d = 1'b0;
          for (int i = 0; i < FULL; i++) begin
            unique case (cmd_ctrl_i.base)
              BASE_HEX: dig_d[i] = ext[4*i +: 4];
              BASE_OCT: dig_d[i] = {1'b0, ext[3*i +: 3]};
              default:  dig_d[i] = 4'd0;
            endcase
          end
          unique case (cmd_ctrl_i.base)
            BASE_HEX: rem_d = REM_W'(HEX_DIGITS);
            BASE_OCT: rem_d = REM_W'(OCT_DIGITS);
            default:  rem_d = REM_W'(DEC_DIGITS);
          endcase
        end
      end
      ST_CONV: begin
        dig_d[0] = {adj[0][2:0], sh_q[VALUE_BITS-1]};
        for (int i = 1; i < FULL; i++) begin
          dig_d[i] = {adj[i][2:0], adj[i-1][3]};
        end
        sh_d  = sh_q << 1;
        cnt_d = cnt_q - CNT_W'(1);
      end
      ST_SKIP: begin
        if (skip_go) begin
          rem_d = rem_q - REM_W'(1);
          if (rem_q > REM_W'(CAP) && top_dig != 4'd0) seen_d = 1'b1;
        end
      end
      ST_PFX0: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.character = CH_ZERO;
          out_d.last      = 1'b0;
        end
      end
      ST_PFX1: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.character = CH_X;
          out_d.last      = ctrl_q.no_digits;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.character = digit_char(top_dig, ctrl_q.upper);
          out_d.last      = (rem_q == REM_W'(1));
          rem_d           = rem_q - REM_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q <= ctrl_d;
    sh_q   <= sh_d;
    dig_q  <= dig_d;
    out_q  <= out_d;
  end

endmodule

// ===== design/unsigned_to_ascii_formatter_top.sv =====
// Top level of the unsigned-to-ASCII formatter (u, x, X, o, p conversions).
// Depends on utaf_pkg, utaf_front, utaf_fifo and utaf_back.
//
// Usage:
//   Input channel: an item (op, length_mode, value, precision_zero) is taken
//   when push is high and full is low. Items land in a two-entry command
//   queue, so up to two can be accepted while the back end is working.
//   Result channel: while empty is low, out_o holds one ASCII character and
//   its last flag; it is taken when pop is high. Characters of one item come
//   most significant first, the final one with last set.
// Sequence per item, with pop keeping up:
//   decimal: the item is loaded and run through the double-dabble loop, then
//   leading zeros are dropped one digit per cycle, then one character per
//   cycle is emitted. Zeros and characters span the 20 decimal places of a
//   64-bit value. Hex, octal and pointer skip the double-dabble loop. The
//   next queued item is loaded right after the last character.
// Reset: asynchronous, active low; empties the queue and the output register.
// Stall: when pop stays low, the back end holds its next character; once the
//   queue is full, full rises and input stalls as well.
module unsigned_to_ascii_formatter_top #(
  parameter int VALUE_BITS = utaf_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = utaf_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  utaf_pkg::in_item_t  in_i,
  output logic                empty,
  input  logic                pop,
  output utaf_pkg::out_item_t out_o
);
  import utaf_pkg::*;

  localparam int CMD_W = $bits(cmd_ctrl_t) + VALUE_BITS;

  cmd_ctrl_t             f_ctrl, b_ctrl;
  logic [VALUE_BITS-1:0] f_value, b_value;
  logic [CMD_W-1:0]      q_rdata;
  logic                  q_full, q_empty, q_pop;
  logic                  back_busy;

  utaf_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .in_i   (in_i),
    .ctrl_o (f_ctrl),
    .value_o(f_value)
  );

  utaf_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i({f_ctrl, f_value}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign full    = q_full;
  assign b_ctrl  = cmd_ctrl_t'(q_rdata[CMD_W-1:VALUE_BITS]);
  assign b_value = q_rdata[VALUE_BITS-1:0];

  utaf_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!q_empty),
    .cmd_ctrl_i (b_ctrl),
    .cmd_value_i(b_value),
    .cmd_pop_o  (q_pop),
    .busy_o     (back_busy),
    .out_pop_i  (pop),
    .out_empty_o(empty),
    .out_o      (out_o)
  );

  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("command queue both full and empty");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end took a command from an empty queue");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> back_busy)
    else $error("back end did not start after taking a command");

endmodule
